/* rtl/core/angle_rate_estimator_assert.svh */
// Assertion macros shared by the angle rate estimator RTL.
`ifndef ANGLE_RATE_ESTIMATOR_ASSERT_SVH
`define ANGLE_RATE_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while rst is high.
`define ARE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst is high.
`define ARE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/are_pkg.sv */
// Package with the constants, codes and shared types of the angle rate estimator.
package are_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ALPHA_FRAC_BITS = 16;

  // Pi in Q32, rounded to the angle fraction width.
  localparam longint unsigned PI_Q32 = 64'd13493037705;
  localparam int PI_Q = int'((PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS)))
                             >> (32 - ANGLE_FRAC_BITS));
  localparam int TWO_PI_Q  = 2 * PI_Q;
  localparam int ALPHA_ONE = 1 << ALPHA_FRAC_BITS;
  localparam int ALPHA_HALF = 1 << (ALPHA_FRAC_BITS - 1);
  localparam int US_PER_S  = 1000000;

  localparam int PA_W      = 16;
  localparam int AA_W      = 24;
  localparam int TS_W      = 32;
  localparam int RATE_W    = 32;
  localparam int PER_W     = 20;
  localparam int ALPHA_W   = 17;
  localparam int PD_W      = 18;
  localparam int AD_W      = 25;
  localparam int MAG_W     = 24;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 20;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int NUM_W     = 44;
  localparam int DEN_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SEEDED     = 2'd1,
    ST_TS_ERR     = 2'd2,
    ST_SAMPLE_ERR = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_PERIOD = 2'd0,
    REG_FILTER_ALPHA  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/core/are_if.sv */
// Channel interfaces of the angle rate estimator: samples, results and configuration.
interface are_sample_if;
  logic                            valid;
  logic                            ready;
  logic signed [are_pkg::PA_W-1:0] pendulum_angle;
  logic signed [are_pkg::AA_W-1:0] arm_angle;
  logic        [are_pkg::TS_W-1:0] sample_time;

  modport source (output valid, pendulum_angle, arm_angle, sample_time, input ready);
  modport sink   (input valid, pendulum_angle, arm_angle, sample_time, output ready);
endinterface

interface are_result_if;
  logic                              valid;
  logic                              ready;
  logic        [1:0]                 status;
  logic signed [are_pkg::PA_W-1:0]   out_pendulum_angle;
  logic signed [are_pkg::RATE_W-1:0] out_pendulum_rate;
  logic signed [are_pkg::AA_W-1:0]   out_arm_angle;
  logic signed [are_pkg::RATE_W-1:0] out_arm_rate;
  logic        [are_pkg::TS_W-1:0]   out_timestamp;

  modport source (output valid, status, out_pendulum_angle, out_pendulum_rate,
                  out_arm_angle, out_arm_rate, out_timestamp, input ready);
  modport sink   (input valid, status, out_pendulum_angle, out_pendulum_rate,
                  out_arm_angle, out_arm_rate, out_timestamp, output ready);
endinterface

interface are_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [are_pkg::CFG_IDX_W-1:0]  index;
  logic [are_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/are_div.sv */
// Restoring radix-2 divider that produces one quotient bit per cycle.
module are_div (
  input  logic                          clk,
  input  logic                          rst,
  input  are_pkg::div_ctrl_t            ctrl,
  input  logic [are_pkg::NUM_W-1:0]     numer,
  input  logic [are_pkg::DEN_W-1:0]     denom,
  output are_pkg::div_stat_t            stat,
  output logic [are_pkg::NUM_W-1:0]     quot
);

  localparam int NUM_W = are_pkg::NUM_W;
  localparam int DEN_W = are_pkg::DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  // The partial remainder stays below the divisor, so it fits DEN_W bits.
  always_comb begin
    shifted  = {rem, quo[NUM_W-1]};
    trial    = {1'b0, shifted} - {2'b00, den};
    fits     = ~trial[DEN_W+1];
    rem_next = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= numer;
        den  <= denom;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};
  assign quot = quo;

endmodule

/* rtl/core/angle_rate_estimator.sv */
// Top level of the angle rate estimator: sequencer, shared multiplier and state.
//
// The block takes one timestamped sample beat on samples and returns one result
// beat on results for every sample. Configuration writes on cfg are always
// accepted (ready is tied high); index 0 sets sample_period_us and index 1 sets
// filter_alpha. They are meant to be written while the block is idle.
// A sample is taken only when the sequencer is idle. A sample with a bad
// pendulum angle, a bad interval, or one that seeds the estimator goes from
// the check state straight to the finish state. A sample that yields rates
// passes the check state, then for each of the two angles one multiply by
// 10^6, one load of the divider, a run of the one-bit-per-cycle divider over
// the 44 quotient bits and an overflow check, then a multiply and an add per
// filter update.
// The result sits in an output register; the sequencer accepts and works on
// the next sample while that result waits, and it stalls only when a second
// result is ready before the first has been taken.
// Reset restores both configuration registers to their defaults, clears the
// seeded flag, the stored angles, timestamp and filtered rates, and drops any
// pending result.
`include "angle_rate_estimator_assert.svh"

module angle_rate_estimator (
  input  logic        clk,
  input  logic        rst,
  are_sample_if.sink  samples,
  are_result_if.source results,
  are_cfg_if.sink     cfg
);

  localparam int PA_W    = are_pkg::PA_W;
  localparam int AA_W    = are_pkg::AA_W;
  localparam int TS_W    = are_pkg::TS_W;
  localparam int RATE_W  = are_pkg::RATE_W;
  localparam int PER_W   = are_pkg::PER_W;
  localparam int ALPHA_W = are_pkg::ALPHA_W;
  localparam int PD_W    = are_pkg::PD_W;
  localparam int AD_W    = are_pkg::AD_W;
  localparam int MAG_W   = are_pkg::MAG_W;
  localparam int MUL_A_W = are_pkg::MUL_A_W;
  localparam int MUL_B_W = are_pkg::MUL_B_W;
  localparam int PROD_W  = are_pkg::PROD_W;
  localparam int NUM_W   = are_pkg::NUM_W;
  localparam int AFB     = are_pkg::ALPHA_FRAC_BITS;

  localparam logic signed [PD_W-1:0] PI_S     = PD_W'(are_pkg::PI_Q);
  localparam logic signed [PD_W-1:0] TWO_PI_S = PD_W'(are_pkg::TWO_PI_Q);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_RMUL   = 9'b000000100,
    S_RDIVS  = 9'b000001000,
    S_RDIV   = 9'b000010000,
    S_RCHK   = 9'b000100000,
    S_FMUL   = 9'b001000000,
    S_FADD   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [PER_W-1:0]   period;
  logic [ALPHA_W-1:0] alpha;

  // Estimator state.
  logic                     seeded;
  logic signed [PA_W-1:0]   last_pa;
  logic signed [AA_W-1:0]   last_aa;
  logic signed [RATE_W-1:0] rate_est [2];
  logic        [TS_W-1:0]   last_ts;

  // Working registers for the sample in flight. Index 0 is the pendulum,
  // index 1 the arm.
  logic signed [PA_W-1:0]   pa;
  logic signed [AA_W-1:0]   aa;
  logic        [TS_W-1:0]   ts;
  logic        [TS_W-1:0]   elapsed;
  logic        [MAG_W-1:0]  mag [2];
  logic                     neg [2];
  logic signed [RATE_W-1:0] raw [2];
  logic signed [RATE_W-1:0] rate_new [2];
  logic                     sel;
  logic                     diff_neg;
  logic        [PROD_W-1:0] prod;
  are_pkg::status_t         res_status;

  // Output register.
  logic                     out_valid;
  are_pkg::status_t         out_status;
  logic signed [PA_W-1:0]   out_pa;
  logic signed [RATE_W-1:0] out_pr;
  logic signed [AA_W-1:0]   out_aa;
  logic signed [RATE_W-1:0] out_ar;
  logic        [TS_W-1:0]   out_ts;

  // Divider connection.
  are_pkg::div_ctrl_t div_ctrl;
  are_pkg::div_stat_t div_stat;
  logic [NUM_W-1:0]   div_quot;
  logic [NUM_W-1:0]   div_numer;

  // Sample checks, evaluated in the check state on the registered sample.
  logic signed [PD_W-1:0] pa_ext;
  logic                   pa_bad;
  logic [TS_W-1:0]        elapsed_c;
  logic [TS_W:0]          twice;
  logic [PER_W+1:0]       per3;
  logic                   ts_bad;
  logic                   is_long;
  logic signed [PD_W-1:0] pd_raw;
  logic signed [PD_W-1:0] pd;
  logic signed [PD_W-1:0] pd_abs;
  logic signed [AD_W-1:0] ad;
  logic signed [AD_W-1:0] ad_abs;

  always_comb begin
    pa_ext    = PD_W'(pa);
    pa_bad    = (pa_ext > PI_S) || (pa_ext < -PI_S);
    elapsed_c = ts - last_ts;
    twice     = {elapsed_c, 1'b0};
    per3      = {2'b00, period} + {1'b0, period, 1'b0};
    ts_bad    = (elapsed_c == '0) || elapsed_c[TS_W-1] || (twice < (TS_W+1)'(period));
    is_long   = twice > (TS_W+1)'(per3);
    // The pendulum delta is wrapped into plus or minus pi.
    pd_raw = pa_ext - PD_W'(last_pa);
    if (pd_raw > PI_S) begin
      pd = pd_raw - TWO_PI_S;
    end else if (pd_raw < -PI_S) begin
      pd = pd_raw + TWO_PI_S;
    end else begin
      pd = pd_raw;
    end
    pd_abs = pd[PD_W-1] ? -pd : pd;
    ad     = AD_W'(aa) - AD_W'(last_aa);
    ad_abs = ad[AD_W-1] ? -ad : ad;
  end

  // Overflow check and sign restore of the raw rate from the divider.
  logic                     rate_ovf;
  logic signed [RATE_W-1:0] raw_c;

  always_comb begin
    if (neg[sel]) begin
      rate_ovf = div_quot > NUM_W'(64'h8000_0000);
      raw_c    = -div_quot[RATE_W-1:0];
    end else begin
      rate_ovf = div_quot > NUM_W'(64'h7FFF_FFFF);
      raw_c    = div_quot[RATE_W-1:0];
    end
  end

  // Filter difference and its magnitude.
  logic signed [RATE_W:0]  fdiff;
  logic        [RATE_W:0]  fdiff_mag;
  logic [ALPHA_W-1:0]      alpha_eff;

  always_comb begin
    fdiff     = (RATE_W+1)'(raw[sel]) - (RATE_W+1)'(rate_est[sel]);
    fdiff_mag = fdiff[RATE_W] ? -fdiff : fdiff;
    // A weight above one acts as one.
    alpha_eff = (alpha > ALPHA_W'(are_pkg::ALPHA_ONE)) ? ALPHA_W'(are_pkg::ALPHA_ONE) : alpha;
  end

  // The one multiplier, shared by the rate scaling and the filter updates.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  always_comb begin
    if (state == S_FMUL) begin
      mul_a = fdiff_mag;
      mul_b = MUL_B_W'(alpha_eff);
    end else begin
      mul_a = MUL_A_W'(mag[sel]);
      mul_b = MUL_B_W'(are_pkg::US_PER_S);
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Rounded filter step and the updated rate.
  logic [PROD_W-1:0]      fsum;
  logic [RATE_W:0]        fstep;
  logic signed [RATE_W+1:0] fnew;

  always_comb begin
    fsum  = prod + PROD_W'(are_pkg::ALPHA_HALF);
    fstep = fsum[AFB +: (RATE_W+1)];
    if (diff_neg) begin
      fnew = (RATE_W+2)'(rate_est[sel]) - (RATE_W+2)'(fstep);
    end else begin
      fnew = (RATE_W+2)'(rate_est[sel]) + (RATE_W+2)'(fstep);
    end
  end

  // Numerator includes half the divisor so the quotient rounds to nearest.
  assign div_numer      = prod[NUM_W-1:0] + NUM_W'(elapsed >> 1);
  assign div_ctrl.start = (state == S_RDIVS);

  are_div u_div (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (div_ctrl),
    .numer (div_numer),
    .denom (elapsed),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  logic finishing;
  assign finishing = (state == S_FINISH) && (!out_valid || results.ready);

  // Configuration port.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PER_W'(1000);
      alpha  <= ALPHA_W'(16384);
    end else if (cfg.valid) begin
      unique case (are_pkg::cfg_reg_t'(cfg.index))
        are_pkg::REG_SAMPLE_PERIOD: period <= cfg.data;
        are_pkg::REG_FILTER_ALPHA:  alpha  <= cfg.data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            pa    <= samples.pendulum_angle;
            aa    <= samples.arm_angle;
            ts    <= samples.sample_time;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          elapsed <= elapsed_c;
          mag[0]  <= MAG_W'(pd_abs);
          neg[0]  <= pd[PD_W-1];
          mag[1]  <= MAG_W'(ad_abs);
          neg[1]  <= ad[AD_W-1];
          sel     <= 1'b0;
          if (pa_bad) begin
            res_status <= are_pkg::ST_SAMPLE_ERR;
            state      <= S_FINISH;
          end else if (!seeded) begin
            res_status <= are_pkg::ST_SEEDED;
            state      <= S_FINISH;
          end else if (ts_bad) begin
            res_status <= are_pkg::ST_TS_ERR;
            state      <= S_FINISH;
          end else if (is_long) begin
            res_status <= are_pkg::ST_SEEDED;
            state      <= S_FINISH;
          end else begin
            res_status <= are_pkg::ST_OK;
            state      <= S_RMUL;
          end
        end
        S_RMUL: begin
          prod  <= mul_p;
          state <= S_RDIVS;
        end
        S_RDIVS: begin
          state <= S_RDIV;
        end
        S_RDIV: begin
          if (div_stat.done) begin
            state <= S_RCHK;
          end
        end
        S_RCHK: begin
          raw[sel] <= raw_c;
          if (rate_ovf) begin
            res_status <= are_pkg::ST_SAMPLE_ERR;
            state      <= S_FINISH;
          end else if (!sel) begin
            sel   <= 1'b1;
            state <= S_RMUL;
          end else begin
            sel   <= 1'b0;
            state <= S_FMUL;
          end
        end
        S_FMUL: begin
          prod     <= mul_p;
          diff_neg <= fdiff[RATE_W];
          state    <= S_FADD;
        end
        S_FADD: begin
          // The filtered rate stays between the old rate and the raw rate.
          rate_new[sel] <= fnew[RATE_W-1:0];
          if (!sel) begin
            sel   <= 1'b1;
            state <= S_FMUL;
          end else begin
            sel   <= 1'b0;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finishing) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Estimator state commits only when the result is loaded, so an error
  // result leaves everything as it was.
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded      <= 1'b0;
      last_pa     <= '0;
      last_aa     <= '0;
      last_ts     <= '0;
      rate_est[0] <= '0;
      rate_est[1] <= '0;
    end else if (finishing) begin
      if (res_status == are_pkg::ST_SEEDED) begin
        seeded      <= 1'b1;
        last_pa     <= pa;
        last_aa     <= aa;
        last_ts     <= ts;
        rate_est[0] <= '0;
        rate_est[1] <= '0;
      end else if (res_status == are_pkg::ST_OK) begin
        last_pa     <= pa;
        last_aa     <= aa;
        last_ts     <= ts;
        rate_est[0] <= rate_new[0];
        rate_est[1] <= rate_new[1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finishing) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finishing) begin
      out_status <= res_status;
      case (res_status)
        are_pkg::ST_OK: begin
          out_pa <= pa;
          out_pr <= rate_new[0];
          out_aa <= aa;
          out_ar <= rate_new[1];
          out_ts <= ts;
        end
        are_pkg::ST_SEEDED: begin
          out_pa <= pa;
          out_pr <= '0;
          out_aa <= aa;
          out_ar <= '0;
          out_ts <= ts;
        end
        default: begin
          out_pa <= '0;
          out_pr <= '0;
          out_aa <= '0;
          out_ar <= '0;
          out_ts <= '0;
        end
      endcase
    end
  end

  assign samples.ready              = (state == S_IDLE);
  assign results.valid              = out_valid;
  assign results.status             = out_status;
  assign results.out_pendulum_angle = out_pa;
  assign results.out_pendulum_rate  = out_pr;
  assign results.out_arm_angle      = out_aa;
  assign results.out_arm_rate       = out_ar;
  assign results.out_timestamp      = out_ts;

  `ARE_ASSERT_NEXT(a_accept_to_check, samples.valid && samples.ready, state == S_CHECK, "accepted sample did not enter the check state")
  `ARE_ASSERT_IMPL(a_div_start_free, div_ctrl.start, !div_stat.busy, "divider started while busy")
  `ARE_ASSERT_IMPL(a_error_zero, results.valid && (results.status == are_pkg::ST_TS_ERR || results.status == are_pkg::ST_SAMPLE_ERR), results.out_pendulum_angle == '0 && results.out_pendulum_rate == '0 && results.out_arm_angle == '0 && results.out_arm_rate == '0 && results.out_timestamp == '0, "error result carries nonzero fields")
  `ARE_ASSERT_IMPL(a_seed_state, results.valid && (results.status == are_pkg::ST_SEEDED || results.status == are_pkg::ST_OK), seeded, "good result without a seeded estimator")

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the angle rate estimator: stimulus, rate prediction and checks.
`timescale 1ns / 1ps

module testbench;
  import are_pkg::*;

  // A cycle count with no beat on any channel that marks the run as hung. The slowest
  // correct stretch is the long result hold-off plus one full rate computation.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // Timestamp base for the directed part, chosen so that the run crosses the 2^32 wrap.
  localparam logic [TS_W-1:0] T0 = 32'hFFFF_FE00;
  // Items per random phase. Six phases give about 1650 items in all with the directed part.
  localparam int unsigned PHASE_ITEMS = 272;
  // Settle time after the last result.
  localparam int unsigned DRAIN_CYCLES = 120;

  typedef struct packed {
    status_t                  status;
    logic signed [PA_W-1:0]   pendulum_angle;
    logic signed [RATE_W-1:0] pendulum_rate;
    logic signed [AA_W-1:0]   arm_angle;
    logic signed [RATE_W-1:0] arm_rate;
    logic        [TS_W-1:0]   timestamp;
  } estimate_t;

  // Keeps its own copy of the estimator state and configuration, works out the
  // estimate each accepted sample beat must produce, and checks result beats
  // against the oldest estimate still waiting.
  class rate_scoreboard;
    logic [PER_W-1:0]   period_us;
    logic [ALPHA_W-1:0] alpha_q16;
    bit                 seeded;
    longint             prev_pa;
    longint             prev_aa;
    longint             pend_rate;
    longint             arm_rate;
    logic [TS_W-1:0]    prev_ts;
    estimate_t          pending_estimates[$];
    int unsigned        failures;

    function new();
      period_us = PER_W'(1000);
      alpha_q16 = ALPHA_W'(16384);
      seeded    = 1'b0;
      prev_pa   = 0;
      prev_aa   = 0;
      pend_rate = 0;
      arm_rate  = 0;
      prev_ts   = '0;
      failures  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] value);
      case (idx)
        REG_SAMPLE_PERIOD: period_us = value[PER_W-1:0];
        REG_FILTER_ALPHA:  alpha_q16 = value[ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_estimates.size();
    endfunction

    function void push_estimate(status_t st, longint pa, longint pr, longint aa, longint ar,
                                logic [TS_W-1:0] ts);
      estimate_t e;
      e.status         = st;
      e.pendulum_angle = pa[PA_W-1:0];
      e.pendulum_rate  = pr[RATE_W-1:0];
      e.arm_angle      = aa[AA_W-1:0];
      e.arm_rate       = ar[RATE_W-1:0];
      e.timestamp      = ts;
      pending_estimates.push_back(e);
    endfunction

    // Seeding stores the angles and the timestamp and clears both filtered rates.
    function void reseed(longint pa, longint aa, logic [TS_W-1:0] ts);
      seeded    = 1'b1;
      prev_pa   = pa;
      prev_aa   = aa;
      pend_rate = 0;
      arm_rate  = 0;
      prev_ts   = ts;
      push_estimate(ST_SEEDED, pa, 0, aa, 0, ts);
    endfunction

    // Angle delta times 10^6 over the elapsed time, rounded half away from zero.
    // Returns 0 when the rate does not fit in a signed 32-bit value.
    function bit scaled_rate(longint delta, longint unsigned elapsed, output longint rate);
      bit              neg;
      longint unsigned mag;
      longint unsigned q;
      neg = delta < 0;
      mag = neg ? -delta : delta;
      q = (mag * longint'(US_PER_S) + elapsed / 2) / elapsed;
      rate = 0;
      if (q > (neg ? 64'd2147483648 : 64'd2147483647))
        return 1'b0;
      rate = neg ? -longint'(q) : longint'(q);
      return 1'b1;
    endfunction

    // One low-pass update: the weighted step is rounded half away from zero.
    function longint lowpass(longint prev, longint raw, longint unsigned weight);
      longint          diff;
      longint unsigned mag;
      longint unsigned s;
      diff = raw - prev;
      mag = (diff < 0) ? -diff : diff;
      s = (mag * weight + longint'(ALPHA_HALF)) >> ALPHA_FRAC_BITS;
      return (diff < 0) ? prev - longint'(s) : prev + longint'(s);
    endfunction

    function void note_sample(logic signed [PA_W-1:0] pa_in, logic signed [AA_W-1:0] aa_in,
                              logic [TS_W-1:0] ts);
      longint          pa;
      longint          aa;
      longint          pd;
      longint          ad;
      longint          praw;
      longint          araw;
      logic [TS_W-1:0] elapsed;
      longint unsigned twice;
      longint unsigned per;
      longint unsigned weight;
      pa = pa_in;
      aa = aa_in;
      // A pendulum angle beyond pi is refused before anything else is looked at.
      if (pa > PI_Q || pa < -PI_Q) begin
        push_estimate(ST_SAMPLE_ERR, 0, 0, 0, 0, '0);
        return;
      end
      if (!seeded) begin
        reseed(pa, aa, ts);
        return;
      end
      elapsed = ts - prev_ts;
      twice = elapsed;
      twice = twice * 2;
      per = period_us;
      if (elapsed == 0 || elapsed[TS_W-1] || twice < per) begin
        push_estimate(ST_TS_ERR, 0, 0, 0, 0, '0);
        return;
      end
      if (twice > 3 * per) begin
        reseed(pa, aa, ts);
        return;
      end
      // The pendulum delta takes the short way around the circle; the arm does not wrap.
      pd = pa - prev_pa;
      if (pd > PI_Q)
        pd -= TWO_PI_Q;
      else if (pd < -PI_Q)
        pd += TWO_PI_Q;
      ad = aa - prev_aa;
      if (!scaled_rate(pd, elapsed, praw) || !scaled_rate(ad, elapsed, araw)) begin
        push_estimate(ST_SAMPLE_ERR, 0, 0, 0, 0, '0);
        return;
      end
      weight = (alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : alpha_q16;
      pend_rate = lowpass(pend_rate, praw, weight);
      arm_rate  = lowpass(arm_rate, araw, weight);
      prev_pa = pa;
      prev_aa = aa;
      prev_ts = ts;
      push_estimate(ST_OK, pa, pend_rate, aa, arm_rate, ts);
    endfunction

    function void check_estimate(logic [1:0] st, logic signed [PA_W-1:0] pa,
                                 logic signed [RATE_W-1:0] pr, logic signed [AA_W-1:0] aa,
                                 logic signed [RATE_W-1:0] ar, logic [TS_W-1:0] ts);
      estimate_t e;
      if (pending_estimates.size() == 0) begin
        $display("%0t: result beat with no sample waiting, status %0d", $time, st);
        failures++;
        return;
      end
      e = pending_estimates.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        failures++;
      end
      if (pa !== e.pendulum_angle) begin
        $display("%0t: pendulum angle expected %0d actual %0d", $time, e.pendulum_angle, pa);
        failures++;
      end
      if (pr !== e.pendulum_rate) begin
        $display("%0t: pendulum rate expected %0d actual %0d", $time, e.pendulum_rate, pr);
        failures++;
      end
      if (aa !== e.arm_angle) begin
        $display("%0t: arm angle expected %0d actual %0d", $time, e.arm_angle, aa);
        failures++;
      end
      if (ar !== e.arm_rate) begin
        $display("%0t: arm rate expected %0d actual %0d", $time, e.arm_rate, ar);
        failures++;
      end
      if (ts !== e.timestamp) begin
        $display("%0t: timestamp expected %0d actual %0d", $time, e.timestamp, ts);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  are_sample_if sif();
  are_result_if rif();
  are_cfg_if    cif();

  angle_rate_estimator DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (sif),
    .results (rif),
    .cfg     (cif)
  );

  rate_scoreboard sb;
  int unsigned    burst_left;
  // Set by the stimulus once, picked up by the receiver to start its long hold-off.
  bit             hold_off_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one sample beat and returns at the edge that accepts it. The sender runs
  // in bursts; at the start of each burst it may drop valid for a random gap, long
  // enough at times to land in the middle of a rate computation.
  task automatic offer_sample(input logic signed [PA_W-1:0] pa,
                              input logic signed [AA_W-1:0] aa,
                              input logic [TS_W-1:0] ts);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
      if (gap != 0) begin
        sif.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sif.valid          <= 1'b1;
    sif.pendulum_angle <= pa;
    sif.arm_angle      <= aa;
    sif.sample_time    <= ts;
    do @(posedge clk); while (!sif.ready);
    // Noted here rather than in a monitor so the next sample is built from up-to-date state.
    sb.note_sample(pa, aa, ts);
  endtask

  // Writes both registers back to back; valid stays high between the two beats.
  task automatic program_filter(input logic [CFG_DAT_W-1:0] period,
                                input logic [CFG_DAT_W-1:0] alpha);
    cif.valid <= 1'b1;
    cif.index <= REG_SAMPLE_PERIOD;
    cif.data  <= period;
    do @(posedge clk); while (!cif.ready);
    sb.set_reg(REG_SAMPLE_PERIOD, period);
    cif.index <= REG_FILTER_ALPHA;
    cif.data  <= alpha;
    do @(posedge clk); while (!cif.ready);
    sb.set_reg(REG_FILTER_ALPHA, alpha);
    cif.valid <= 1'b0;
  endtask

  // Builds the next sample from the state the estimator holds now. Most samples continue
  // the motion inside the admissible timing window so that rates get computed and
  // filtered; the rest reseed, break the timing, leave the pendulum range or are noise.
  function automatic void next_sample(output logic signed [PA_W-1:0] pa,
                                      output logic signed [AA_W-1:0] aa,
                                      output logic [TS_W-1:0] ts);
    int unsigned     pick;
    int unsigned     mag;
    longint          v;
    longint unsigned p;
    logic [TS_W-1:0] elapsed;
    p = sb.period_us;
    pick = $urandom_range(0, 99);

    // Pendulum moves mostly a little, sometimes far enough to wrap around pi.
    mag = $urandom_range(0, 9);
    mag = (mag < 6) ? 200 : (mag < 9) ? 5000 : PI_Q;
    v = sb.prev_pa + longint'($urandom_range(0, 2 * mag)) - longint'(mag);
    if (v > PI_Q)
      v -= TWO_PI_Q;
    else if (v < -PI_Q)
      v += TWO_PI_Q;
    pa = v[PA_W-1:0];

    // The arm steps small or medium; a large jump wraps the 24-bit angle and tends
    // to overflow the rate.
    mag = $urandom_range(0, 9);
    if (mag == 9) begin
      aa = AA_W'($urandom);
    end else begin
      mag = (mag < 7) ? 2000 : 200000;
      v = sb.prev_aa + longint'($urandom_range(0, 2 * mag)) - longint'(mag);
      aa = v[AA_W-1:0];
    end

    if (p == 0)
      elapsed = $urandom_range(1, 3000);
    else
      elapsed = $urandom_range((p + 1) / 2, (3 * p) / 2);

    if (pick >= 70 && pick < 78) begin
      // Longer than one and a half periods: reseeds.
      elapsed = TS_W'((p == 0) ? $urandom_range(1, 1000) :
                                 (3 * p) / 2 + 1 + $urandom_range(0, p));
    end else if (pick >= 78 && pick < 85) begin
      case ($urandom_range(0, 2))
        0: elapsed = '0;
        1: elapsed = 32'h8000_0000 | $urandom;
        default: elapsed = (p >= 2) ? $urandom_range(0, (p - 1) / 2) : 0;
      endcase
    end else if (pick >= 85 && pick < 90) begin
      v = $urandom_range(PI_Q + 1, 32767);
      if ($urandom_range(0, 1))
        v = -v - 1;
      pa = v[PA_W-1:0];
    end else if (pick >= 90) begin
      pa = PA_W'($urandom);
      aa = AA_W'($urandom);
      elapsed = $urandom;
    end
    ts = sb.prev_ts + elapsed;
  endfunction

  // Receiver: ready follows a pattern of its own, switching between always ready,
  // coin toss, mostly stalled and mostly ready. On request it holds off for a long
  // stretch so that the block backs up and stalls its input.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    rif.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = 600;
      end
      if (hold_left != 0) begin
        hold_left--;
        rif.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0: rif.ready <= 1'b1;
          1: rif.ready <= ($urandom_range(0, 1) == 1);
          2: rif.ready <= ($urandom_range(0, 3) == 0);
          default: rif.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      @(posedge clk);
    end
  end

  // Result checker: every accepted result beat is compared with the oldest estimate.
  always @(posedge clk) begin
    if (!rst && rif.valid && rif.ready)
      sb.check_estimate(rif.status, rif.out_pendulum_angle, rif.out_pendulum_rate,
                        rif.out_arm_angle, rif.out_arm_rate, rif.out_timestamp);
  end

  // Watchdog: ends the run when no beat has moved on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((sif.valid && sif.ready) || (rif.valid && rif.ready) || (cif.valid && cif.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic signed [PA_W-1:0] pa;
    logic signed [AA_W-1:0] aa;
    logic [TS_W-1:0]        ts;
    logic [CFG_DAT_W-1:0]   per;
    logic [CFG_DAT_W-1:0]   alf;
    int unsigned            phase;
    sb = new();
    burst_left   = 0;
    hold_off_req = 1'b0;
    rst                <= 1'b1;
    sif.valid          <= 1'b0;
    sif.pendulum_angle <= '0;
    sif.arm_angle      <= '0;
    sif.sample_time    <= '0;
    cif.valid          <= 1'b0;
    cif.index          <= REG_SAMPLE_PERIOD;
    cif.data           <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings (period 1000 us, alpha one quarter).
    // Pendulum angles just past pi and at the field extremes are refused, even
    // before the first sample has seeded the estimator.
    offer_sample(16'sd25737, 24'sd0, 32'd5);
    offer_sample(-16'sd32768, 24'sd8388607, 32'd7);
    // First good sample seeds at the largest legal angles, just before the timestamp wraps.
    offer_sample(16'sd25736, 24'sd8388607, T0);
    // Zero, backwards and too-short intervals are timestamp errors.
    offer_sample(-16'sd25736, 24'sd8388507, T0);
    offer_sample(16'sd0, 24'sd0, T0 - 32'd10);
    offer_sample(16'sd0, 24'sd0, T0 + 32'd499);
    // Half a period exactly; the pendulum goes from +pi to -pi, which wraps to no motion.
    offer_sample(-16'sd25736, 24'sd8388507, T0 + 32'd500);
    // One and a half periods exactly, across the timestamp wrap, pendulum wrapping the other way.
    offer_sample(16'sd25000, 24'sd8388407, T0 + 32'd2000);
    // One microsecond beyond one and a half periods reseeds.
    offer_sample(-16'sd25000, 24'sd8388000, T0 + 32'd3501);
    // An arm jump across the whole range overflows the rate.
    offer_sample(-16'sd24000, -24'sd8388608, T0 + 32'd4501);
    offer_sample(16'sd32767, 24'sd0, T0 + 32'd4600);
    offer_sample(-16'sd25737, 24'sd0, T0 + 32'd4700);
    // Reseed at the most negative arm angle, then a normal step from there.
    offer_sample(-16'sd24000, -24'sd8388608, T0 + 32'd9000);
    offer_sample(-16'sd23990, -24'sd8388600, T0 + 32'd9800);
    // A one-count delta over 640 us lands exactly halfway; rounding goes away from zero.
    offer_sample(-16'sd23989, -24'sd8388600, T0 + 32'd10440);
    offer_sample(-16'sd23990, -24'sd8388601, T0 + 32'd11080);
    offer_sample(16'sd25736, 24'sd8388607, T0 + 32'd12580);
    sif.valid <= 1'b0;
    burst_left = 0;

    // Random phases, each with its own period and filter weight: weight one, weight
    // zero with a one-microsecond period, a zero period, the widest period with a
    // weight above one, the largest nominal period, and a random pair.
    for (phase = 0; phase < 6; phase++) begin
      while (sb.pending() != 0) @(posedge clk);
      case (phase)
        0: begin per = CFG_DAT_W'(1000); alf = CFG_DAT_W'(ALPHA_ONE); end
        1: begin per = CFG_DAT_W'(1); alf = '0; end
        2: begin per = '0; alf = CFG_DAT_W'(16384); end
        3: begin per = {PER_W{1'b1}}; alf = CFG_DAT_W'(100000); end
        4: begin per = CFG_DAT_W'(1000000); alf = CFG_DAT_W'(1); end
        default: begin
          per = CFG_DAT_W'($urandom_range(2, 5000));
          alf = CFG_DAT_W'($urandom_range(0, ALPHA_ONE));
        end
      endcase
      program_filter(per, alf);
      if (phase == 5)
        hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        next_sample(pa, aa, ts);
        offer_sample(pa, aa, ts);
      end
      sif.valid <= 1'b0;
      burst_left = 0;
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d estimates never arrived", $time, sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
